### rtl/audio_ring_fifo_prefill_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio ring FIFO with prefill
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_FIFO_PREFILL_TOP_ASSERT_SVH
`define AUDIO_RING_FIFO_PREFILL_TOP_ASSERT_SVH

// Same-cycle implication property.
`define ARFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a result in the next.
`define ARFP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/arfp_pkg.sv
// ----------------------------------------------------------------------------
// arfp_pkg
// Constants and codes for the audio ring FIFO with prefill.
// ----------------------------------------------------------------------------
package arfp_pkg;

  localparam int unsigned DEPTH_DEF     = 4096;
  localparam int unsigned CHUNK_DEF     = 64;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PLW           = 12;  // prefill level
  localparam int unsigned LMW           = 8;   // underrun limit
  localparam int unsigned SCW           = 9;   // underrun score
  localparam int unsigned CFG_IW        = 1;
  localparam int unsigned CFG_DW        = 12;

  localparam logic [PLW-1:0] PREFILL_RST = PLW'(2731);
  localparam logic [LMW-1:0] LIMIT_RST   = LMW'(8);

  localparam int unsigned FREE_MIN      = 4;
  localparam int unsigned SCORE_STEP    = 2;

  localparam logic [CFG_IW-1:0] REG_PREFILL = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_LIMIT   = CFG_IW'(1);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PLAY  = 1'b1;

  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_REJECTED = 3'd1,
    ST_PLAYED   = 3'd2,
    ST_PREFILL  = 3'd3,
    ST_UNDERRUN = 3'd4
  } status_e;

endpackage

### rtl/audio_ring_fifo_prefill_top.sv
// ----------------------------------------------------------------------------
// audio_ring_fifo_prefill_top
// Write item: one result beat in the cycle after accept; busy stays low, so
//   writes go at one per cycle.
// Play item: busy until its chunk is out; CHUNK_BYTES beats, one byte per
//   cycle, from the sample RAM when played, zero on prefill or underrun;
//   the last one in the first cycle with busy low. No new item while busy.
// Reset: indices and score cleared, prefill armed, registers at defaults.
//   Sample RAM is not cleared. Result beats cannot be stalled.
// ----------------------------------------------------------------------------
`include "audio_ring_fifo_prefill_top_assert.svh"

module audio_ring_fifo_prefill_top
  import arfp_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_DEF,
  localparam int unsigned AW         = $clog2(DEPTH),
  localparam int unsigned FW         = AW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              kind_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output logic              out_valid_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [2:0]        status_o,
  output logic              restarted_o,
  output logic              last_o,
  output logic [FW-1:0]     fill_level_o
);

  localparam int unsigned CNW = $clog2(CHUNK_BYTES);
  localparam int unsigned CMW = (AW > PLW) ? AW : PLW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SILENCE,
    S_PLAY
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     wr_idx_q, wr_idx_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [AW-1:0]     raddr_q, raddr_d;
  logic              prefilling_q, prefilling_d;
  logic [SCW-1:0]    score_q, score_d;
  logic [PLW-1:0]    prefill_q;
  logic [LMW-1:0]    limit_q;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic              from_mem_q, from_mem_d;
  status_e           status_q, status_d;
  logic              restart_q, restart_d;
  logic [FW-1:0]     fill_q, fill_d;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;

  logic [AW-1:0]     held;
  logic [AW-1:0]     wr_inc;
  logic [AW-1:0]     raddr_inc;
  logic [AW-1:0]     rd_adv;
  logic [FW-1:0]     rd_sum;
  logic [SCW:0]      score_add;
  logic [SCW-1:0]    score_sat;

  assign busy = (state_q != S_IDLE);

  // ring arithmetic, valid for any DEPTH
  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      held = wr_idx_q - rd_idx_q;
    end else begin
      held = AW'(FW'(wr_idx_q) + FW'(DEPTH) - FW'(rd_idx_q));
    end
    wr_inc    = (wr_idx_q == AW'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
    raddr_inc = (raddr_q == AW'(DEPTH - 1)) ? '0 : raddr_q + 1'b1;
    rd_sum    = FW'(rd_idx_q) + FW'(CHUNK_BYTES);
    rd_adv    = (rd_sum >= FW'(DEPTH)) ? AW'(rd_sum - FW'(DEPTH)) : AW'(rd_sum);
    score_add = {1'b0, score_q} + (SCW + 1)'(SCORE_STEP);
    score_sat = score_add[SCW] ? '1 : score_add[SCW-1:0];
  end

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    raddr_d      = raddr_q;
    prefilling_d = prefilling_q;
    score_d      = score_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    restart_d    = restart_q;
    fill_d       = fill_q;
    valid_d      = 1'b0;
    last_d       = 1'b0;
    from_mem_d   = 1'b0;
    mem_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          restart_d = 1'b0;
          if (kind_i == KIND_WRITE) begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            if (held < AW'(DEPTH - FREE_MIN)) begin
              mem_we   = 1'b1;
              wr_idx_d = wr_inc;
              status_d = ST_WRITTEN;
              fill_d   = FW'(held) + 1'b1;
            end else begin
              status_d = ST_REJECTED;
              fill_d   = FW'(held);
            end
          end else begin
            cnt_d = '0;
            if (prefilling_q && (CMW'(wr_idx_q) < CMW'(prefill_q))) begin
              status_d = ST_PREFILL;
              fill_d   = FW'(held);
              state_d  = S_SILENCE;
            end else begin
              prefilling_d = 1'b0;
              if (held < AW'(CHUNK_BYTES)) begin
                status_d = ST_UNDERRUN;
                fill_d   = FW'(held);
                score_d  = score_sat;
                state_d  = S_SILENCE;
                if (score_sat > SCW'(limit_q)) begin
                  score_d      = '0;
                  wr_idx_d     = '0;
                  rd_idx_d     = '0;
                  prefilling_d = 1'b1;
                  restart_d    = 1'b1;
                  fill_d       = '0;
                end
              end else begin
                status_d = ST_PLAYED;
                fill_d   = FW'(held) - FW'(CHUNK_BYTES);
                raddr_d  = rd_idx_q;
                rd_idx_d = rd_adv;
                state_d  = S_PLAY;
                if (score_q != '0) begin
                  score_d = score_q - 1'b1;
                end
              end
            end
          end
        end
      end
      S_SILENCE, S_PLAY: begin
        valid_d    = 1'b1;
        from_mem_d = (state_q == S_PLAY);
        raddr_d    = raddr_inc;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNW'(CHUNK_BYTES - 1)) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      raddr_q      <= '0;
      prefilling_q <= 1'b1;
      score_q      <= '0;
      prefill_q    <= PREFILL_RST;
      limit_q      <= LIMIT_RST;
      cnt_q        <= '0;
      valid_q      <= 1'b0;
      last_q       <= 1'b0;
      from_mem_q   <= 1'b0;
      status_q     <= ST_WRITTEN;
      restart_q    <= 1'b0;
      fill_q       <= '0;
    end else begin
      state_q      <= state_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      raddr_q      <= raddr_d;
      prefilling_q <= prefilling_d;
      score_q      <= score_d;
      cnt_q        <= cnt_d;
      valid_q      <= valid_d;
      last_q       <= last_d;
      from_mem_q   <= from_mem_d;
      status_q     <= status_d;
      restart_q    <= restart_d;
      fill_q       <= fill_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PREFILL: prefill_q <= cfg_data_i[PLW-1:0];
          REG_LIMIT:   limit_q   <= cfg_data_i[LMW-1:0];
          default: ;
        endcase
      end
    end
  end

  // sample RAM: writes only while idle, read data used only while playing
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= in_byte_i;
    end
    rdata_q <= mem_q[raddr_q];
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = from_mem_q ? rdata_q : '0;
  assign status_o     = status_q;
  assign restarted_o  = restart_q;
  assign last_o       = last_q;
  assign fill_level_o = fill_q;

  `ARFP_ASSERT_NEXT(a_write_beat, start && !busy && kind_i == KIND_WRITE,
    out_valid_o && last_o && !restarted_o, "write item did not give one final beat")
  `ARFP_ASSERT_NEXT(a_play_busy, start && !busy && kind_i == KIND_PLAY,
    busy && !out_valid_o, "play item did not hold busy")
  `ARFP_ASSERT(a_restart_empty, out_valid_o && restarted_o |->
    fill_level_o == '0 && status_o == ST_UNDERRUN, "restart beat not empty underrun")
  `ARFP_ASSERT(a_data_played, out_valid_o && out_byte_o != '0 |->
    status_o == ST_PLAYED, "nonzero byte on a non-play beat")

endmodule
